// ----- hw/rtl/cpc_pkg.sv -----
// Shared types and constants for the clock and power register file.
// No dependencies.
`default_nettype none
package cpc_pkg;
    localparam logic [7:0] OFS_LOCK   = 8'h00;
    localparam logic [7:0] OFS_MPLL   = 8'h04;
    localparam logic [7:0] OFS_UPLL   = 8'h08;
    localparam logic [7:0] OFS_CLKCON = 8'h0c;
    localparam logic [7:0] OFS_SLOW   = 8'h10;
    localparam logic [7:0] OFS_DIV    = 8'h14;
    localparam logic [31:0] LOCK_RST   = 32'h00ff_ffff;
    localparam logic [31:0] MPLL_RST   = 32'h0005_c080;
    localparam logic [31:0] UPLL_RST   = 32'h0002_8080;
    localparam logic [31:0] CLKCON_RST = 32'h0007_fff0;
    localparam logic [31:0] SLOW_RST   = 32'h0000_0004;
    localparam logic [31:0] POFF_VAL   = 32'h0007_fff0;
    localparam logic [26:0] REF_RST    = 27'd12000000;
    localparam int DW = 40;   // dividend width (holds the 27 x 9 bit product)

    // datapath commands from the controller
    typedef struct packed {
        logic ld_mpll;     // start divide for main PLL
        logic ld_upll;
        logic ld_slow;
        logic div_step;
        logic st_mclk;
        logic st_uclk;
        logic st_fslow;
        logic finish;      // compute F/H/P and latch
    } cpc_cmd_t;

    typedef struct packed {
        logic div_done;
    } cpc_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/clock_power_controller_regs_unit.sv -----
// Top level of the clock and power register file.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
`default_nettype none
// Six 32-bit registers at byte offsets 0x00..0x14. Reads, and writes to lock
// time or clock control, reach the output register in the cycle after
// acceptance. Writes to the PLL, slow-clock or divider registers recompute the
// clocks with one shared restoring divider at one quotient bit per cycle: three
// 40-bit divisions plus load and finish steps, before the result is offered.
// Reference clock changes take effect at the next recomputing write.
module clock_power_controller_regs_unit import cpc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [26:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [7:0]  register_offset,
    input  wire logic [31:0] write_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      read_data,
    output logic [31:0]      mclk_hz,
    output logic [31:0]      uclk_hz,
    output logic [31:0]      fclk_hz,
    output logic [31:0]      hclk_hz,
    output logic [31:0]      pclk_hz,
    output logic [2:0]       bus_clk_ratio,
    output logic             power_off_request,
    output logic             idle_request
);
    logic [26:0] ref_reg;
    logic [31:0] lock_reg, mpll_reg, upll_reg, con_reg, slow_reg, div_reg;
    logic pend_reg, ovld_reg, busy, start, acc, ofs_ok, recomp;
    logic [31:0] rd_reg; logic poff_reg, idle_reg;
    logic [31:0] rd_sel;
    logic clkcon_wr;
    cpc_cmd_t cmd; cpc_sts_t sts;

    assign cfg_ready = 1'b1;
    assign in_ready = !pend_reg && !busy && !ovld_reg;
    assign acc = in_valid && in_ready;
    assign ofs_ok = (register_offset[1:0] == 2'b00) && (register_offset <= OFS_DIV);
    assign recomp = acc && command && ofs_ok &&
                    (register_offset == OFS_MPLL || register_offset == OFS_UPLL ||
                     register_offset == OFS_SLOW || register_offset == OFS_DIV);
    assign clkcon_wr = command && ofs_ok && (register_offset == OFS_CLKCON);

    always_comb
    begin
        case (register_offset)
            OFS_LOCK:   rd_sel = lock_reg;
            OFS_MPLL:   rd_sel = mpll_reg;
            OFS_UPLL:   rd_sel = upll_reg;
            OFS_CLKCON: rd_sel = con_reg;
            OFS_SLOW:   rd_sel = slow_reg;
            default:    rd_sel = div_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= REF_RST; lock_reg <= LOCK_RST; mpll_reg <= MPLL_RST;
            upll_reg <= UPLL_RST; con_reg <= CLKCON_RST; slow_reg <= SLOW_RST;
            div_reg <= '0; pend_reg <= 1'b0; ovld_reg <= 1'b0;
            rd_reg <= '0; poff_reg <= 1'b0; idle_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid) ref_reg <= cfg_data;
            if (out_valid && out_ready) ovld_reg <= 1'b0;
            // recomputing write: hold result until finish
            if (pend_reg && cmd.finish)
            begin
                pend_reg <= 1'b0; ovld_reg <= 1'b1;
            end
            if (acc)
            begin
                if (!command) rd_reg <= ofs_ok ? rd_sel : 32'hffff_ffff;
                else          rd_reg <= '0;
                poff_reg <= clkcon_wr && write_data[3];
                idle_reg <= clkcon_wr && !write_data[3] && !con_reg[2] && write_data[2];
                if (command && ofs_ok)
                begin
                    case (register_offset)
                        OFS_LOCK:   lock_reg <= write_data;
                        OFS_CLKCON: con_reg <= write_data[3] ? POFF_VAL : write_data;
                        OFS_MPLL:   mpll_reg <= write_data;
                        OFS_UPLL:   upll_reg <= write_data;
                        OFS_SLOW:   slow_reg <= write_data;
                        default:    div_reg <= write_data;
                    endcase
                end
                if (recomp) pend_reg <= 1'b1;
                else        ovld_reg <= 1'b1;
            end
        end
    end
    // start in the cycle after the write so the datapath sees new registers
    logic go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) go_reg <= 1'b0;
        else        go_reg <= recomp;
    end
    assign start = go_reg;

    cpc_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
                     .cmd(cmd), .busy(busy));
    cpc_datapath u_dp (.clk(clk), .rst_n(rst_n), .ref_hz(ref_reg), .mpll(mpll_reg),
                       .upll(upll_reg), .slow(slow_reg), .divr(div_reg), .cmd(cmd),
                       .sts(sts), .mclk_o(mclk_hz), .uclk_o(uclk_hz), .fclk_o(fclk_hz),
                       .hclk_o(hclk_hz), .pclk_o(pclk_hz), .ratio_o(bus_clk_ratio));

    assign out_valid = ovld_reg;
    assign read_data = rd_reg;
    assign power_off_request = poff_reg;
    assign idle_request = idle_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/cpc_ctrl.sv -----
// Sequencer for clock recompute: three serial divisions then a finish step.
// Depends on cpc_pkg.
`default_nettype none
module cpc_ctrl import cpc_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire cpc_sts_t sts,
    output cpc_cmd_t      cmd,
    output logic          busy
);
    localparam logic [2:0] S_IDLE = 3'd0, S_DM = 3'd1, S_LU = 3'd2, S_DU = 3'd3,
                           S_LS = 3'd4, S_DS = 3'd5, S_FIN = 3'd6;
    logic [2:0] state_reg, state_next;
    // reset clocks are held as constants in the datapath, no recompute here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (start)
            begin
                cmd.ld_mpll = 1'b1;
                state_next = S_DM;
            end
            S_DM:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.st_mclk = 1'b1;
                    state_next = S_LU;
                end
            end
            S_LU:
            begin
                cmd.ld_upll = 1'b1;
                state_next = S_DU;
            end
            S_DU:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.st_uclk = 1'b1;
                    state_next = S_LS;
                end
            end
            S_LS:
            begin
                cmd.ld_slow = 1'b1;
                state_next = S_DS;
            end
            S_DS:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.st_fslow = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// ----- hw/rtl/cpc_datapath.sv -----
// Registers, multiplier and restoring divider for the derived clocks.
// Depends on cpc_pkg.
`default_nettype none
module cpc_datapath import cpc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [26:0] ref_hz,
    input  wire logic [31:0] mpll,
    input  wire logic [31:0] upll,
    input  wire logic [31:0] slow,
    input  wire logic [31:0] divr,
    input  wire cpc_cmd_t    cmd,
    output cpc_sts_t         sts,
    output logic [31:0]      mclk_o,
    output logic [31:0]      uclk_o,
    output logic [31:0]      fclk_o,
    output logic [31:0]      hclk_o,
    output logic [31:0]      pclk_o,
    output logic [2:0]       ratio_o
);
    logic [DW-1:0] rem_reg, rem_next;    // dividend shifting out
    logic [11:0]   dvs_reg, dvs_next;    // divisor (max 65<<3)
    logic [DW-1:0] q_reg, q_next;
    logic [11:0]   part_reg, part_next;  // partial remainder
    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0] mclk_reg, uclk_reg, fs_reg;
    logic [31:0] f_reg, h_reg, p_reg;
    logic [2:0]  r_reg;

    function automatic logic [DW-1:0] pll_num(input logic [26:0] r, input logic [31:0] s);
        logic [8:0] m;
        m = {1'b0, s[19:12]} + 9'd8;
        return DW'(r) * DW'(m);
    endfunction
    function automatic logic [11:0] pll_den(input logic [31:0] s);
        logic [6:0] p;
        p = {1'b0, s[9:4]} + 7'd2;
        return 12'({5'd0, p} << s[1:0]);
    endfunction

    logic [12:0] trial;
    always_comb
    begin
        rem_next = rem_reg; dvs_next = dvs_reg; q_next = q_reg;
        part_next = part_reg; cnt_next = cnt_reg;
        trial = {part_reg, rem_reg[DW-1]} - {1'b0, dvs_reg};
        if (cmd.ld_mpll || cmd.ld_upll || cmd.ld_slow)
        begin
            part_next = '0; q_next = '0; cnt_next = 6'(DW);
            if (cmd.ld_mpll)
            begin
                rem_next = pll_num(ref_hz, mpll); dvs_next = pll_den(mpll);
            end
            else if (cmd.ld_upll)
            begin
                rem_next = pll_num(ref_hz, upll); dvs_next = pll_den(upll);
            end
            else
            begin
                rem_next = DW'(ref_hz);
                dvs_next = (slow[2:0] == 3'd0) ? 12'd1 : {8'd0, slow[2:0], 1'b0};
            end
        end
        else if (cmd.div_step)
        begin
            rem_next = {rem_reg[DW-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (!trial[12])
            begin
                part_next = trial[11:0]; q_next = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                part_next = {part_reg[10:0], rem_reg[DW-1]}; q_next = {q_reg[DW-2:0], 1'b0};
            end
        end
    end
    assign sts.div_done = (cnt_reg == 6'd0);

    logic [31:0] qsat, fsel;
    assign qsat = (q_reg[DW-1:32] != '0) ? 32'hffff_ffff : q_reg[31:0];
    assign fsel = slow[4] ? fs_reg : mclk_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            mclk_reg <= 32'd120000000; uclk_reg <= 32'd57600000; fs_reg <= '0;
            f_reg <= 32'd120000000; h_reg <= 32'd120000000; p_reg <= 32'd120000000;
            r_reg <= 3'd1;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.st_mclk)  mclk_reg <= qsat;
            if (cmd.st_uclk)  uclk_reg <= qsat;
            if (cmd.st_fslow) fs_reg <= qsat;
            if (cmd.finish)
            begin
                f_reg <= fsel;
                if (divr[2])
                begin
                    h_reg <= fsel >> 2; p_reg <= fsel >> 2; r_reg <= 3'd4;
                end
                else
                begin
                    case (divr[1:0])
                        2'd0: begin h_reg <= fsel; p_reg <= fsel; r_reg <= 3'd1; end
                        2'd1: begin h_reg <= fsel; p_reg <= fsel >> 1; r_reg <= 3'd2; end
                        2'd2: begin h_reg <= fsel >> 1; p_reg <= fsel >> 1; r_reg <= 3'd2; end
                        default: begin h_reg <= fsel >> 1; p_reg <= fsel >> 2; r_reg <= 3'd4; end
                    endcase
                end
            end
        end
    end
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next; dvs_reg <= dvs_next; q_reg <= q_next; part_reg <= part_next;
    end
    assign mclk_o = mclk_reg; assign uclk_o = uclk_reg; assign fclk_o = f_reg;
    assign hclk_o = h_reg; assign pclk_o = p_reg; assign ratio_o = r_reg;
endmodule
`default_nettype wire

// ----- bench/tb_clock_power_controller_regs_unit.sv -----
// Self-checking bench for the clock and power register file: a predictor and
// scoreboard class, handshake driver tasks and random idling phases.
// Depends on cpc_pkg and clock_power_controller_regs_unit.
`timescale 1ns / 1ps
module tb_clock_power_controller_regs_unit;
    import cpc_pkg::*;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [31:0] BIT_IDLE = 32'h4;
    localparam logic [31:0] BIT_POFF = 32'h8;
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [31:0] rd;
        logic [31:0] m, u, f, h, p;
        logic [2:0]  ratio;
        logic        poff, idle;
    } clk_result_t;

    int errors = 0;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    class clock_scoreboard;
        logic [26:0] ref_hz;
        logic [31:0] regs [6];
        logic [31:0] m, u, f, h, p;
        logic [2:0]  ratio;
        clk_result_t pending[$];

        function new();
            ref_hz = REF_RST;
            regs[0] = LOCK_RST; regs[1] = MPLL_RST; regs[2] = UPLL_RST;
            regs[3] = CLKCON_RST; regs[4] = SLOW_RST; regs[5] = 32'd0;
            recalc();
        endfunction

        function logic [31:0] pll_hz(input logic [31:0] s);
            logic [63:0] num, den, q;
            num = 64'(ref_hz) * (64'(s[19:12]) + 64'd8);
            den = (64'(s[9:4]) + 64'd2) << s[1:0];
            q = num / den;
            return (q > 64'hffff_ffff) ? ALL_ONES : q[31:0];
        endfunction

        function void recalc();
            logic [31:0] slow;
            m = pll_hz(regs[1]);
            u = pll_hz(regs[2]);
            slow = regs[4];
            if (slow[4])
                f = (slow[2:0] == 0) ? 32'(ref_hz) : 32'(ref_hz) / (2 * slow[2:0]);
            else
                f = m;
            if (regs[5][2]) begin
                h = f / 4; p = f / 4; ratio = 3'd4;
            end
            else begin
                case (regs[5][1:0])
                    2'd0: begin h = f; p = f; ratio = 3'd1; end
                    2'd1: begin h = f; p = f / 2; ratio = 3'd2; end
                    2'd2: begin h = f / 2; p = h; ratio = 3'd2; end
                    default: begin h = f / 2; p = h / 2; ratio = 3'd4; end
                endcase
            end
        endfunction

        function void note_access(input logic cmd, input logic [7:0] ofs,
                                  input logic [31:0] data);
            clk_result_t r;
            logic ok;
            int idx;
            ok = (ofs[1:0] == 0) && (ofs <= OFS_DIV);
            idx = ofs >> 2;
            r = '0;
            if (cmd == CMD_READ)
                r.rd = ok ? regs[idx] : ALL_ONES;
            else if (ok) begin
                if (ofs == OFS_CLKCON) begin
                    if (data & BIT_POFF) begin
                        regs[3] = POFF_VAL; r.poff = 1;
                    end
                    else begin
                        r.idle = ((regs[3] & BIT_IDLE) == 0) && ((data & BIT_IDLE) != 0);
                        regs[3] = data;
                    end
                end
                else begin
                    regs[idx] = data;
                    if (ofs != OFS_LOCK) recalc();
                end
            end
            r.m = m; r.u = u; r.f = f; r.h = h; r.p = p; r.ratio = ratio;
            pending.push_back(r);
        endfunction

        task check_result(input clk_result_t got);
            clk_result_t w;
            if (pending.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.rd != w.rd) report("read_data", got.rd, w.rd);
            if (got.m != w.m) report("mclk_hz", got.m, w.m);
            if (got.u != w.u) report("uclk_hz", got.u, w.u);
            if (got.f != w.f) report("fclk_hz", got.f, w.f);
            if (got.h != w.h) report("hclk_hz", got.h, w.h);
            if (got.p != w.p) report("pclk_hz", got.p, w.p);
            if (got.ratio != w.ratio) report("bus_clk_ratio", 32'(got.ratio), 32'(w.ratio));
            if (got.poff != w.poff) report("power_off_request", 32'(got.poff), 32'(w.poff));
            if (got.idle != w.idle) report("idle_request", 32'(got.idle), 32'(w.idle));
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [26:0] cfg_data = '0;
    logic in_valid = 0, in_ready;
    logic command = 0;
    logic [7:0] register_offset = '0;
    logic [31:0] write_data = '0;
    logic out_valid, out_ready = 0;
    logic [31:0] read_data, mclk_hz, uclk_hz, fclk_hz, hclk_hz, pclk_hz;
    logic [2:0] bus_clk_ratio;
    logic power_off_request, idle_request;

    clock_power_controller_regs_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .register_offset(register_offset), .write_data(write_data),
        .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
        .mclk_hz(mclk_hz), .uclk_hz(uclk_hz), .fclk_hz(fclk_hz),
        .hclk_hz(hclk_hz), .pclk_hz(pclk_hz), .bus_clk_ratio(bus_clk_ratio),
        .power_off_request(power_off_request), .idle_request(idle_request)
    );

    clock_scoreboard sb = new();
    int send_idle_pct = 0, stall_pct = 0;
    logic hold_rx = 0;
    longint cycles = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: sample the result at the edge, then pick ready for the next one.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({read_data, mclk_hz, uclk_hz, fclk_hz, hclk_hz, pclk_hz,
                             bus_clk_ratio, power_off_request, idle_request});
        if (hold_rx)
            out_ready <= 0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold valid across back-to-back transactions; drop it only while idling.
    task automatic send_access(input logic cmd, input logic [7:0] ofs,
                               input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1; command <= cmd; register_offset <= ofs; write_data <= data;
        do @(posedge clk); while (!in_ready);
        sb.note_access(cmd, ofs, data);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_ref(input logic [26:0] hz);
        cfg_valid <= 1; cfg_data <= hz;
        do @(posedge clk); while (!cfg_ready);
        sb.ref_hz = hz;
        cfg_valid <= 0;
    endtask

    function automatic logic [7:0] pick_offset();
        if ($urandom_range(9) == 0) return 8'($urandom);
        return 8'($urandom_range(5) * 4);
    endfunction

    function automatic logic [31:0] pick_data();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom & 32'h000f_f3f7;
            2: return $urandom_range(31);
            default: return $urandom & ~BIT_POFF;
        endcase
    endfunction

    task automatic random_run(input int n);
        repeat (n) send_access(logic'($urandom_range(1)), pick_offset(), pick_data());
    endtask

    initial begin
        logic [26:0] refs [5];
        refs = '{27'd1, 27'd100000000, 27'd0, 27'd7_654_321, 27'h7ff_ffff};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: reset reads, extremes, special cases
        for (int i = 0; i < 6; i++) send_access(CMD_READ, 8'(i * 4), 0);
        send_access(CMD_READ, 8'h02, 0);
        send_access(CMD_READ, 8'hff, 0);
        send_access(CMD_WRITE, 8'h18, ALL_ONES);
        send_access(CMD_WRITE, OFS_MPLL, 32'h000f_f003);
        send_access(CMD_WRITE, OFS_MPLL, 32'h0000_03f0);
        send_access(CMD_WRITE, OFS_UPLL, ALL_ONES);
        send_access(CMD_WRITE, OFS_SLOW, 32'h10);
        send_access(CMD_WRITE, OFS_SLOW, 32'h17);
        for (int d = 0; d < 5; d++) send_access(CMD_WRITE, OFS_DIV, 32'(d));
        send_access(CMD_WRITE, OFS_CLKCON, 32'h0);
        send_access(CMD_WRITE, OFS_CLKCON, BIT_IDLE);
        send_access(CMD_WRITE, OFS_CLKCON, BIT_IDLE);
        send_access(CMD_WRITE, OFS_CLKCON, ALL_ONES);
        send_access(CMD_WRITE, OFS_LOCK, 0);
        send_access(CMD_READ, OFS_CLKCON, 0);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            write_ref(refs[ph]);
            send_idle_pct = (ph == 1 || ph == 3) ? 65 : 0;
            stall_pct = (ph == 2 || ph == 3) ? 65 : 0;
            if (ph == 3) begin
                send_idle_pct = 18; stall_pct = 18;
            end
            // long receiver hold-off while the sender keeps offering
            if (ph == 4)
                fork
                    begin
                        hold_rx = 1;
                        repeat (3000) @(posedge clk);
                        hold_rx = 0;
                    end
                join_none
            random_run(300);
            drain();
        end
        write_ref(REF_RST);
        random_run(20);
        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
